/* src/pjwh_pkg.sv */
// Package for the PJW hash linear probe table: sizes, status codes and types.
// Used by every module of the block but pjwh_ram.
`timescale 1ns / 1ps
package pjwh_pkg;
	localparam int TableDepth = 64;
	localparam int MaxKeyBytes = 16;
	localparam int ValueBits = 32;
	localparam int SlotW = $clog2(TableDepth);
	localparam int KeyIdxW = $clog2(MaxKeyBytes);
	localparam int KeyCntW = $clog2(MaxKeyBytes + 1);
	localparam int KeyMemDepth = TableDepth * MaxKeyBytes;
	localparam int KeyMemW = SlotW + KeyIdxW;
	localparam int LenW = 7;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_FOUND = 3'd1,
		ST_FULL = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_TOO_LONG = 3'd4
	} status_t;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	// One key operation handed from the front to the back
	typedef struct packed {
		logic cmd;
		logic overlong;
		logic [31:0] hash;
		logic [KeyCntW-1:0] count;
		logic [ValueBits-1:0] value;
		logic [MaxKeyBytes*8-1:0] key;
	} op_t;

	// PJW fold of one byte into the running hash
	function automatic logic [31:0] pjw_fold(input logic [31:0] h, input logic [7:0] b);
		logic [31:0] t;
		logic [31:0] top;
		t = {h[27:0], 4'd0} + {24'd0, b};
		top = t & 32'hF000_0000;
		pjw_fold = (t ^ (top >> 24)) & ~top;
	endfunction
endpackage

/* src/pjw_hash_linear_probe_table_unit.sv */
// PJW hash table with linear probing. Key bytes are taken one per cycle
// while the op queue does not stall a last beat; an op then passes the queue,
// a restoring remainder, a read and check of each probed slot, a compare of
// key bytes (one more step to close a match) or a write of the key bytes (at
// least one), and output; an overlong key goes straight to output. One op in
// the back end, two may queue. Reset (arst_n, asynchronous) empties the table,
// clears key state and sets the table length to 64; no clearing pass is needed.
`timescale 1ns / 1ps
module pjw_hash_linear_probe_table_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [6:0] cfg_wdata,
	input  logic in_valid,
	output logic in_stall,
	input  logic command,
	input  logic [7:0] key_byte,
	input  logic key_last,
	input  logic [31:0] entry_value,
	output logic out_valid,
	input  logic out_stall,
	output logic [2:0] status,
	output logic [31:0] found_value,
	output logic [5:0] slot_index
);
	import pjwh_pkg::*;

	logic [LenW-1:0] len_q;
	logic f_valid, f_stall, q_valid, q_take;
	op_t f_op, q_op;

	// table length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) len_q <= LenW'(TableDepth);
		else if (cfg_we) len_q <= cfg_wdata;
	end

	pjwh_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.command(command), .key_byte(key_byte), .key_last(key_last),
		.entry_value(entry_value), .op_valid(f_valid), .op_stall(f_stall), .op(f_op));

	pjwh_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_valid(f_valid), .wr_stall(f_stall),
		.wr_op(f_op), .rd_valid(q_valid), .rd_take(q_take), .rd_op(q_op));

	pjwh_back u_back (
		.clk(clk), .arst_n(arst_n), .table_length(len_q), .op_valid(q_valid),
		.op_take(q_take), .op(q_op), .res_valid(out_valid), .res_stall(out_stall),
		.status(status), .found_value(found_value), .slot_index(slot_index));
endmodule

/* src/pjwh_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module pjwh_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0] wdata,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

/* src/pjwh_front.sv */
// Front end: collects key bytes, folds the PJW hash, issues one op per key.
// Depends on pjwh_pkg.
`timescale 1ns / 1ps
module pjwh_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic command,
	input  logic [7:0] key_byte,
	input  logic key_last,
	input  logic [pjwh_pkg::ValueBits-1:0] entry_value,
	output logic op_valid,
	input  logic op_stall,
	output pjwh_pkg::op_t op
);
	import pjwh_pkg::*;

	logic [31:0] hash_q;
	logic [KeyCntW-1:0] count_q;
	logic overlong_q;
	logic [MaxKeyBytes*8-1:0] key_q;
	logic [31:0] hash_d;
	logic [KeyCntW-1:0] count_d;
	logic overlong_d;
	logic [MaxKeyBytes*8-1:0] key_d;
	logic take;

	// a last beat waits while the op queue is full
	assign in_stall = key_last && op_stall;
	assign take = in_valid && !in_stall;

	always_comb begin
		hash_d = hash_q;
		count_d = count_q;
		overlong_d = overlong_q;
		key_d = key_q;
		if (key_byte != 8'd0) begin
			if (count_q >= KeyCntW'(MaxKeyBytes)) begin
				overlong_d = 1'b1;
			end else begin
				key_d[count_q[KeyIdxW-1:0]*8 +: 8] = key_byte;
				count_d = count_q + KeyCntW'(1);
				hash_d = pjw_fold(hash_q, key_byte);
			end
		end
	end

	assign op_valid = in_valid && key_last;
	assign op.cmd = command;
	assign op.overlong = overlong_d;
	assign op.hash = hash_d;
	assign op.count = count_d;
	assign op.value = entry_value;
	assign op.key = key_d;

	// key state; cleared after the last beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
			count_q <= '0;
			overlong_q <= 1'b0;
		end else if (take) begin
			if (key_last) begin
				hash_q <= '0;
				count_q <= '0;
				overlong_q <= 1'b0;
			end else begin
				hash_q <= hash_d;
				count_q <= count_d;
				overlong_q <= overlong_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			key_q <= key_d;
		end
	end
endmodule

/* src/pjwh_queue.sv */
// Two-entry op queue between front and back.
// Depends on pjwh_pkg.
`timescale 1ns / 1ps
module pjwh_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_stall,
	input  pjwh_pkg::op_t wr_op,
	output logic rd_valid,
	input  logic rd_take,
	output pjwh_pkg::op_t rd_op
);
	import pjwh_pkg::*;

	op_t ent_q [2];
	logic rp_q;
	logic wp_q;
	logic [1:0] cnt_q;
	logic push;

	assign wr_stall = cnt_q == 2'd2;
	assign push = wr_valid && !wr_stall;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_op = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q <= 1'b0;
			wp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (rd_take) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, rd_take};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= wr_op;
		end
	end
endmodule

/* src/pjwh_back.sv */
// Back end: modulo, linear probe walk, key compare and slot writes.
// Depends on pjwh_pkg and pjwh_ram.
`timescale 1ns / 1ps
module pjwh_back (
	input  logic clk,
	input  logic arst_n,
	input  logic [pjwh_pkg::LenW-1:0] table_length,
	input  logic op_valid,
	output logic op_take,
	input  pjwh_pkg::op_t op,
	output logic res_valid,
	input  logic res_stall,
	output logic [2:0] status,
	output logic [31:0] found_value,
	output logic [5:0] slot_index
);
	import pjwh_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_MOD  = 7'b0000010,
		S_RD   = 7'b0000100,
		S_CHK  = 7'b0001000,
		S_CMP  = 7'b0010000,
		S_WR   = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t state_q;
	op_t op_q;
	logic [SlotW:0] len_q;
	logic [5:0] mod_step_q;
	logic [SlotW-1:0] slot_q;
	logic [SlotW:0] probed_q;
	logic [KeyCntW-1:0] bi_q;
	logic [TableDepth-1:0] occ_q;
	logic [2:0] st_q;
	logic [31:0] fval_q;
	logic [5:0] idx_q;
	logic res_q;
	logic res_load;
	logic [2:0] res_st_q;
	logic [31:0] res_fval_q;
	logic [5:0] res_idx_q;

	// slot memories
	logic kb_we, kc_we, vl_we;
	logic [KeyMemW-1:0] kb_addr;
	logic [KeyIdxW-1:0] kb_byte;
	logic [7:0] kb_rd;
	logic [KeyCntW-1:0] kc_rd;
	logic [ValueBits-1:0] vl_rd;
	logic [SlotW:0] len_use;
	logic [SlotW:0] next_slot;
	logic [7:0] buf_byte;

	always_comb begin
		if (table_length == '0) len_use = (SlotW+1)'(1);
		else if (table_length > LenW'(TableDepth)) len_use = (SlotW+1)'(TableDepth);
		else len_use = table_length[SlotW:0];
	end

	// while comparing, fetch the byte needed on the next cycle
	assign kb_byte = (state_q == S_CMP) ? bi_q[KeyIdxW-1:0] + KeyIdxW'(1) :
		bi_q[KeyIdxW-1:0];
	assign kb_addr = {slot_q, kb_byte};
	assign buf_byte = op_q.key[bi_q[KeyIdxW-1:0]*8 +: 8];
	assign next_slot = ({1'b0, slot_q} + 1'b1 == len_q) ? '0 : {1'b0, slot_q} + 1'b1;

	pjwh_ram #(.Width(8), .Depth(KeyMemDepth)) u_keys (
		.clk(clk), .we(kb_we), .addr(kb_addr), .wdata(buf_byte), .rdata(kb_rd));
	pjwh_ram #(.Width(KeyCntW), .Depth(TableDepth)) u_kcnt (
		.clk(clk), .we(kc_we), .addr(slot_q), .wdata(op_q.count), .rdata(kc_rd));
	pjwh_ram #(.Width(ValueBits), .Depth(TableDepth)) u_vals (
		.clk(clk), .we(vl_we), .addr(slot_q), .wdata(op_q.value), .rdata(vl_rd));

	assign kb_we = (state_q == S_WR) && (bi_q < op_q.count);
	assign kc_we = (state_q == S_WR) && (bi_q == '0);
	assign vl_we = kc_we;

	assign op_take = state_q == S_IDLE && op_valid;
	assign res_load = (state_q == S_OUT) && (!res_q || !res_stall);
	assign res_valid = res_q;
	assign status = res_st_q;
	assign found_value = res_fval_q;
	assign slot_index = res_idx_q;

	// restoring remainder, one quotient bit per cycle
	logic [63:0] div_rem_q;
	logic [63:0] div_shift;
	assign div_shift = {div_rem_q[62:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			occ_q <= '0;
			res_q <= 1'b0;
		end else begin
			res_q <= res_load || (res_q && res_stall);
			case (state_q)
				S_IDLE: if (op_valid) begin
					state_q <= op.overlong ? S_OUT : S_MOD;
				end
				S_MOD: if (mod_step_q == 6'd31) state_q <= S_RD;
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					if (op_q.cmd == CMD_INSERT) begin
						if (!occ_q[slot_q]) begin
							occ_q[slot_q] <= 1'b1;
							state_q <= S_WR;
						end else if (probed_q + 1'b1 == len_q) state_q <= S_OUT;
						else state_q <= S_RD;
					end else begin
						if (!occ_q[slot_q]) state_q <= S_OUT;
						else if (kc_rd == op_q.count) state_q <= S_CMP;
						else if (probed_q + 1'b1 == len_q) state_q <= S_OUT;
						else state_q <= S_RD;
					end
				end
				S_CMP: begin
					if (bi_q >= op_q.count) state_q <= S_OUT;
					else if (kb_rd != op_q.key[bi_q[KeyIdxW-1:0]*8 +: 8]) begin
						state_q <= (probed_q + 1'b1 == len_q) ? S_OUT : S_RD;
					end
				end
				S_WR: if (bi_q + 1'b1 >= op_q.count || op_q.count == '0) state_q <= S_OUT;
				S_OUT: if (res_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register, held while the beat is stalled
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_st_q <= st_q;
			res_fval_q <= fval_q;
			res_idx_q <= idx_q;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q <= op;
				len_q <= len_use;
				mod_step_q <= '0;
				div_rem_q <= {32'd0, op.hash};
				slot_q <= '0;
				probed_q <= '0;
				bi_q <= '0;
				st_q <= ST_TOO_LONG;
				fval_q <= '0;
				idx_q <= '0;
			end
			S_MOD: begin
				mod_step_q <= mod_step_q + 6'd1;
				if (div_shift[63:32] >= {{(32-SlotW-1){1'b0}}, len_q})
					div_rem_q <= {div_shift[63:32] - {{(32-SlotW-1){1'b0}}, len_q},
						div_shift[31:0]};
				else
					div_rem_q <= div_shift;
				if (mod_step_q == 6'd31) begin
					slot_q <= (div_shift[63:32] >= {{(32-SlotW-1){1'b0}}, len_q}) ?
						SlotW'(div_shift[63:32] - {{(32-SlotW-1){1'b0}}, len_q}) :
						SlotW'(div_shift[63:32]);
					st_q <= (op_q.cmd == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
				end
			end
			S_RD: bi_q <= '0;
			S_CHK: begin
				if (op_q.cmd == CMD_INSERT) begin
					if (!occ_q[slot_q]) begin
						st_q <= ST_INSERTED;
						idx_q <= 6'(slot_q);
					end else begin
						slot_q <= next_slot[SlotW-1:0];
						probed_q <= probed_q + 1'b1;
					end
				end else if (occ_q[slot_q] && kc_rd != op_q.count) begin
					slot_q <= next_slot[SlotW-1:0];
					probed_q <= probed_q + 1'b1;
				end
			end
			S_CMP: begin
				if (bi_q >= op_q.count) begin
					st_q <= ST_FOUND;
					fval_q <= 32'(vl_rd);
					idx_q <= 6'(slot_q);
				end else if (kb_rd != op_q.key[bi_q[KeyIdxW-1:0]*8 +: 8]) begin
					slot_q <= next_slot[SlotW-1:0];
					probed_q <= probed_q + 1'b1;
				end else begin
					bi_q <= bi_q + 1'b1;
				end
			end
			S_WR: bi_q <= bi_q + 1'b1;
			default: ;
		endcase
	end
endmodule

/* tb/sv/pjwh_scoreboard.sv */
// Checker for the PJW hash linear probe table: mirrors the table, predicts
// each result beat and compares it with what the unit returns. Needs pjwh_pkg.
`timescale 1ns / 1ps
module pjwh_scoreboard (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [6:0] cfg_wdata,
	input  logic in_valid,
	input  logic in_stall,
	input  logic command,
	input  logic [7:0] key_byte,
	input  logic key_last,
	input  logic [31:0] entry_value,
	input  logic out_valid,
	input  logic out_stall,
	input  logic [2:0] status,
	input  logic [31:0] found_value,
	input  logic [5:0] slot_index,
	output int fail_count,
	output int pending_results
);
	import pjwh_pkg::*;

	typedef struct packed {
		status_t st;
		logic [31:0] fval;
		logic [5:0] idx;
	} lookup_result_t;

	lookup_result_t expected_q[$];

	// mirrored state
	logic [6:0] len_reg;
	logic [31:0] hash_acc;
	logic [7:0] key_buf [MaxKeyBytes];
	int key_cnt;
	logic too_long;
	logic occ [TableDepth];
	logic [7:0] slot_key [TableDepth][MaxKeyBytes];
	int slot_cnt [TableDepth];
	logic [31:0] slot_val [TableDepth];

	assign pending_results = expected_q.size();

	function automatic logic [31:0] fold_byte(logic [31:0] h, logic [7:0] b);
		logic [31:0] t;
		logic [31:0] top;
		t = (h << 4) + {24'd0, b};
		top = t & 32'hF000_0000;
		if (top != 0)
			t = t ^ (top >> 24);
		return t & ~top;
	endfunction

	function automatic bit key_equal(int w);
		if (slot_cnt[w] != key_cnt)
			return 0;
		for (int k = 0; k < key_cnt; k++)
			if (slot_key[w][k] != key_buf[k])
				return 0;
		return 1;
	endfunction

	// one accepted input beat
	task automatic take_beat(logic cmd, logic [7:0] b, logic last, logic [31:0] v);
		lookup_result_t r;
		int len;
		int start;
		int w;
		if (b != 0) begin
			if (key_cnt >= MaxKeyBytes)
				too_long = 1'b1;
			else begin
				key_buf[key_cnt] = b;
				key_cnt++;
				hash_acc = fold_byte(hash_acc, b);
			end
		end
		if (!last)
			return;
		r.fval = '0;
		r.idx = '0;
		if (too_long)
			r.st = ST_TOO_LONG;
		else begin
			len = (len_reg == 0) ? 1 : (len_reg > TableDepth) ? TableDepth : len_reg;
			start = hash_acc % len;
			if (cmd == CMD_INSERT) begin
				r.st = ST_FULL;
				for (int i = 0; i < len; i++) begin
					w = (start + i) % len;
					if (!occ[w]) begin
						occ[w] = 1'b1;
						for (int k = 0; k < key_cnt; k++)
							slot_key[w][k] = key_buf[k];
						slot_cnt[w] = key_cnt;
						slot_val[w] = v;
						r.st = ST_INSERTED;
						r.idx = 6'(w);
						break;
					end
				end
			end else begin
				r.st = ST_NOT_FOUND;
				for (int i = 0; i < len; i++) begin
					w = (start + i) % len;
					if (!occ[w])
						break;
					if (key_equal(w)) begin
						r.st = ST_FOUND;
						r.fval = slot_val[w];
						r.idx = 6'(w);
						break;
					end
				end
			end
		end
		hash_acc = '0;
		key_cnt = 0;
		too_long = 1'b0;
		expected_q.push_back(r);
	endtask

	// sample both channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		lookup_result_t e;
		if (!arst_n) begin
			len_reg = 7'd64;
			hash_acc = '0;
			key_cnt = 0;
			too_long = 1'b0;
			for (int i = 0; i < TableDepth; i++)
				occ[i] = 1'b0;
			expected_q.delete();
			fail_count = 0;
		end else begin
			if (cfg_we)
				len_reg = cfg_wdata;
			if (in_valid && !in_stall)
				take_beat(command, key_byte, key_last, entry_value);
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result beat: status %0d value %h slot %0d",
							status, found_value, slot_index);
				end else begin
					e = expected_q.pop_front();
					if (status !== e.st || found_value !== e.fval || slot_index !== e.idx) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: exp st %0d val %h slot %0d, got %0d %h %0d",
								e.st, e.fval, e.idx, status, found_value, slot_index);
					end
				end
			end
		end
	end
endmodule

/* tb/sv/pjw_hash_linear_probe_table_unit_tb.sv */
// Top of the testbench: drives keys and table lengths into the unit, with
// random idling on both channels. Needs pjwh_pkg, pjwh_scoreboard and the unit.
`timescale 1ns / 1ps
module pjw_hash_linear_probe_table_unit_tb;
	import pjwh_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [6:0] cfg_wdata = 0;
	logic in_valid = 0;
	logic in_stall;
	logic command = 0;
	logic [7:0] key_byte = 0;
	logic key_last = 0;
	logic [31:0] entry_value = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [2:0] status;
	logic [31:0] found_value;
	logic [5:0] slot_index;
	int fail_count;
	int pending_results;

	bit quiet_mode = 0;   // no idling in the last part
	bit hold_req = 0;     // long receiver hold-off
	int beat_total = 0;
	int key_total = 0;

	// small key pool so searches hit often
	logic [7:0] pool [8][MaxKeyBytes];
	int pool_len [8];

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	pjw_hash_linear_probe_table_unit DUT (.*);

	pjwh_scoreboard u_scoreboard (.*);

	// receiver stall, in bursts, with a long hold on request
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1;
				repeat (300) @(negedge clk);
				out_stall <= 0;
				hold_req = 0;
			end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 8);
				out_stall <= 1;
				repeat (n) @(negedge clk);
				out_stall <= 0;
			end
		end
	end

	// one beat; sender idles at random before it
	task automatic send_beat(logic cmd, logic [7:0] b, logic last, logic [31:0] v);
		if (!quiet_mode && $urandom_range(0, 6) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		in_valid <= 1;
		command <= cmd;
		key_byte <= b;
		key_last <= last;
		entry_value <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		beat_total++;
		if (last)
			key_total++;
	endtask

	task automatic send_key(logic cmd, int p, logic [31:0] v);
		if (pool_len[p] == 0)
			send_beat(cmd, 8'd0, 1'b1, v);
		else
			for (int k = 0; k < pool_len[p]; k++)
				send_beat(cmd, pool[p][k], k == pool_len[p] - 1, v);
	endtask

	// wait till idle, then let the back end drain
	task automatic drain();
		in_valid <= 0;
		while (pending_results != 0)
			@(negedge clk);
		repeat (2500) @(negedge clk);
	endtask

	task automatic set_length(logic [6:0] n);
		drain();
		cfg_we <= 1;
		cfg_wdata <= n;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic random_pool();
		for (int p = 0; p < 8; p++) begin
			pool_len[p] = (p == 0) ? 0 : $urandom_range(1, (p == 7) ? MaxKeyBytes : 6);
			for (int k = 0; k < MaxKeyBytes; k++)
				pool[p][k] = 8'($urandom_range(1, 255));
		end
	endtask

	initial begin
		logic [6:0] lengths [6] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd5, 7'd64};
		int n;
		repeat (12) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		random_pool();

		// directed: empty key, extreme byte values, zero inside key, overlong
		send_key(CMD_SEARCH, 0, 32'd0);
		send_key(CMD_INSERT, 0, 32'hFFFF_FFFF);
		send_key(CMD_SEARCH, 0, 32'd0);
		send_beat(CMD_INSERT, 8'hFF, 1'b0, 32'd0);
		send_beat(CMD_INSERT, 8'h00, 1'b0, 32'd0);
		send_beat(CMD_INSERT, 8'h01, 1'b1, 32'h1234_5678);
		send_beat(CMD_SEARCH, 8'hFF, 1'b0, 32'd0);
		send_beat(CMD_SEARCH, 8'h01, 1'b1, 32'd0);
		for (int k = 0; k < MaxKeyBytes + 1; k++)
			send_beat(CMD_INSERT, 8'hA5, k == MaxKeyBytes, 32'd0);
		send_key(CMD_SEARCH, 7, 32'd0);

		// phases over table lengths, extremes included
		for (int ph = 0; ph < 6; ph++) begin
			set_length(lengths[ph]);
			if (ph == 5)
				quiet_mode = 1;
			n = 0;
			while (n < 25) begin
				if (ph == 2 && n == 8)
					hold_req = 1;
				if (ph == 3 && n == 10)
					drain();
				if ($urandom_range(0, 19) == 0) begin
					// noise: random bytes, random lengths
					repeat ($urandom_range(1, 20))
						send_beat(1'($urandom), 8'($urandom), $urandom_range(0, 3) == 0,
							$urandom);
					send_beat(1'($urandom), 8'($urandom), 1'b1, $urandom);
				end else
					send_key($urandom_range(0, 2) != 0, $urandom_range(0, 7), $urandom);
				n++;
			end
		end
		drain();
		$display("covered %0d beats, %0d keys over six table lengths incl. 0, 1, 64, 127",
			beat_total, key_total);
		if (fail_count == 0)
			$display("** pjw_hash_linear_probe_table_unit: PASSED **");
		else
			$display("** pjw_hash_linear_probe_table_unit: FAILED **");
		$finish;
	end

	initial begin
		#20ms;
		$display("** pjw_hash_linear_probe_table_unit: FAILED **");
		$finish;
	end
endmodule
